FILE: rtl/slpc_pkg.sv
package slpc_pkg;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_UNLOCKED  = 1'b0;
  localparam logic REG_BOOT_TIME = 1'b1;

  localparam int TICK_DIVIDE_DEF = 3;
  localparam int DIV_W = 8;

  // Motion controller states
  localparam logic [3:0] STATE_DISABLED   = 4'd0;
  localparam logic [3:0] STATE_IDLE       = 4'd1;
  localparam logic [3:0] STATE_ACCEL      = 4'd2;
  localparam logic [3:0] STATE_MOVING     = 4'd3;
  localparam logic [3:0] STATE_DECEL      = 4'd4;
  localparam logic [3:0] STATE_HOMING     = 4'd5;
  localparam logic [3:0] STATE_HARD_LIMIT = 4'd6;
  localparam logic [3:0] STATE_ERROR      = 4'd7;
  localparam logic [3:0] STATE_PATH       = 4'd8;
  localparam logic [3:0] STATE_LOCKED     = 4'd9;
  localparam logic [3:0] PATTERN_ROWS     = 4'd10;

  // Pattern ROM: bit i of a row is the LED level at phase i.
  localparam logic [63:0] PATTERN_ROM [10] = '{
    64'h0000_0000_0000_0111,
    64'h0000_0000_0000_0001,
    64'h1F81_F01E_01C0_1801,
    64'h0FC1_F83F_0FC1_F83F,
    64'h1003_0070_0F01_F03F,
    64'h0861_C79F_0861_C79F,
    64'h0000_0000_03C0_780F,
    64'h0000_003F_FFC0_780F,
    64'h1111_1111_1111_1111,
    64'h001F_E001_001F_E001
  };

  // Reciprocals for exact division by a constant: q = (x * M) >> K.
  localparam logic [27:0] RCP5_K30    = 28'd214748365;   // 28-bit x / 5
  localparam logic [31:0] RCP125_K38  = 32'd2199023256;  // 31-bit x / 125
  localparam logic [29:0] RCP125_K36  = 30'd549755814;   // 29-bit x / 125
  localparam logic [15:0] RCP125_K22  = 16'd33555;       // 15-bit x / 125

  typedef struct packed {
    logic [31:0] now_ms;
    logic [3:0]  mc_state;
    logic        drive_fault;
    logic        underrun_latched;
    logic        uic_linked;
  } in_item_t;

  typedef struct packed {
    logic       led_on;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // Per-item control carried down the pipeline next to the rainbow datapath.
  typedef struct packed {
    logic [3:0] st;
    logic       locked;
    logic       drv;
    logic       under;
    logic       link;
    logic [5:0] phase;
    logic       blink80;
    logic       blink250;
  } ctl_t;

endpackage

FILE: rtl/slpc_rainbow.sv
module slpc_rainbow (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] elapsed,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);
  import slpc_pkg::*;

  logic [58:0] q_prod;
  logic [22:0] q;
  logic [9:0]  elo;
  logic [9:0]  rem_next;
  logic [9:0]  rem;
  logic [17:0] rem255;
  logic [30:0] hue_prod;
  logic [7:0]  hue;
  logic [7:0]  p;
  logic [7:0]  seg;
  logic [7:0]  seg3;
  logic [7:0]  wr_next;
  logic [7:0]  wg_next;
  logic [7:0]  wb_next;
  logic [7:0]  wr;
  logic [7:0]  wg;
  logic [7:0]  wb;

  function automatic logic [7:0] scale140(input logic [7:0] c);
    logic [15:0] x;
    logic [16:0] y;
    begin
      x = {1'b0, c, 7'b0} + {5'b0, c, 3'b0} + {6'b0, c, 2'b0};
      // Exact x / 255 for x below 65535.
      y = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
      scale140 = y[15:8];
    end
  endfunction

  // Quotient of elapsed / 1000, taken as (elapsed >> 3) / 125.
  assign q_prod = {30'b0, elapsed[31:3]} * {29'b0, RCP125_K36};

  // Remainder only needs ten bits: q * 1000 is -q * 24 modulo 1024.
  assign rem_next = elo + {q[5:0], 4'b0} + {q[6:0], 3'b0};

  // hue = rem * 255 / 1000.
  assign rem255   = {rem, 8'b0} - {8'b0, rem};
  assign hue_prod = {16'b0, rem255[17:3]} * {15'b0, RCP125_K22};

  always_comb begin
    p = ~hue;
    wr_next = 8'd0;
    wg_next = 8'd0;
    wb_next = 8'd0;
    if (p < 8'd85) begin
      seg = p;
    end else if (p < 8'd170) begin
      seg = p - 8'd85;
    end else begin
      seg = p - 8'd170;
    end
    seg3 = {seg[6:0], 1'b0} + seg;
    if (p < 8'd85) begin
      wr_next = 8'd255 - seg3;
      wb_next = seg3;
    end else if (p < 8'd170) begin
      wg_next = seg3;
      wb_next = 8'd255 - seg3;
    end else begin
      wr_next = seg3;
      wg_next = 8'd255 - seg3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q   <= q_prod[58:36];
      elo <= elapsed[9:0];
      rem <= rem_next;
      hue <= hue_prod[29:22];
      wr  <= wr_next;
      wg  <= wg_next;
      wb  <= wb_next;
    end
  end

  assign red   = scale140(wr);
  assign green = scale140(wg);
  assign blue  = scale140(wb);

endmodule

FILE: rtl/status_led_pattern_and_color_core.sv
// Channel   Direction  Signals                        Transaction
// in        input      in_valid, in_ready, in_data    one heartbeat tick
// out       output     out_valid, out_ready, out_data one LED level and RGB pixel
// cfg       input      psel, penable, pwrite, paddr,  register write or read
//                      pwdata, prdata, pready
//
// One tick is accepted per cycle while the output is not stalled; for every
// TICK_DIVIDE-th tick out_valid rises once the tick has passed through five
// pipeline registers and the output register.
// The length is set by the rainbow path: two reciprocal multiplies for the
// modulo-1000 hue, with a register after each, and the colour wheel.
// Reset clears tick divider, phase counter, config registers and all valid bits.
// A stalled output holds the whole pipeline; in_ready follows out_ready then.
module status_led_pattern_and_color_core #(
  parameter int TICK_DIVIDE = slpc_pkg::TICK_DIVIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  slpc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output slpc_pkg::out_item_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slpc_pkg::PADDR_W-1:0]      paddr,
  input  logic [slpc_pkg::PDATA_W-1:0]      pwdata,
  output logic [slpc_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import slpc_pkg::*;

  logic              unlocked;
  logic [31:0]       boot_time_ms;
  logic [DIV_W-1:0]  tick_divider;
  logic [DIV_W-1:0]  div_inc;
  logic              div_hit;
  logic [5:0]        phase_counter;
  logic [5:0]        phase_next;
  logic              en;
  logic              accept;

  logic              a_vld, b_vld, c_vld, d_vld, e_vld;
  ctl_t              a_ctl_next;
  ctl_t              a_ctl, b_ctl, c_ctl, d_ctl, e_ctl;
  ctl_t              b_ctl_next;
  logic [31:0]       a_now;
  logic [31:0]       a_elapsed;
  logic [55:0]       prod80;
  logic [62:0]       prod250;
  logic [7:0]        rb_red, rb_green, rb_blue;
  out_item_t         out_next;
  logic              blink;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unlocked     <= 1'b0;
      boot_time_ms <= 32'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_UNLOCKED:  unlocked     <= pwdata[0];
        REG_BOOT_TIME: boot_time_ms <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_UNLOCKED:  prdata = {31'b0, unlocked};
      REG_BOOT_TIME: prdata = boot_time_ms;
      default:       prdata = '0;
    endcase
  end

  // The whole pipeline advances together unless a finished result is stuck.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;

  assign div_inc    = tick_divider + 1'b1;
  assign div_hit    = div_inc >= DIV_W'(TICK_DIVIDE);
  assign phase_next = phase_counter + 6'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divider  <= '0;
      phase_counter <= '0;
    end else if (accept) begin
      if (div_hit) begin
        tick_divider  <= '0;
        phase_counter <= phase_next;
      end else begin
        tick_divider <= div_inc;
      end
    end
  end

  always_comb begin
    a_ctl_next          = '0;
    a_ctl_next.st       = unlocked ? in_data.mc_state : STATE_LOCKED;
    a_ctl_next.locked   = !unlocked;
    a_ctl_next.drv      = in_data.drive_fault;
    a_ctl_next.under    = in_data.underrun_latched;
    a_ctl_next.link     = in_data.uic_linked;
    a_ctl_next.phase    = phase_next;
  end

  // Blink phases: bit 0 of now / 80 and now / 250.
  assign prod80  = {28'b0, a_now[31:4]} * {28'b0, RCP5_K30};
  assign prod250 = {32'b0, a_now[31:1]} * {31'b0, RCP125_K38};

  always_comb begin
    b_ctl_next          = a_ctl;
    b_ctl_next.blink80  = prod80[30];
    b_ctl_next.blink250 = prod250[38];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      d_vld     <= 1'b0;
      e_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_vld     <= in_valid && div_hit;
      b_vld     <= a_vld;
      c_vld     <= b_vld;
      d_vld     <= c_vld;
      e_vld     <= d_vld;
      out_valid <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctl     <= a_ctl_next;
      a_now     <= in_data.now_ms;
      a_elapsed <= in_data.now_ms - boot_time_ms;
      b_ctl     <= b_ctl_next;
      c_ctl     <= b_ctl;
      d_ctl     <= c_ctl;
      e_ctl     <= d_ctl;
      out_data  <= out_next;
    end
  end

  slpc_rainbow u_rainbow (
    .clk     (clk),
    .en      (en),
    .elapsed (a_elapsed),
    .red     (rb_red),
    .green   (rb_green),
    .blue    (rb_blue)
  );

  // Colour priority chain and pattern lookup.
  always_comb begin
    out_next = '0;
    blink    = 1'b0;
    if (e_ctl.locked) begin
      out_next.red   = rb_red;
      out_next.green = rb_green;
      out_next.blue  = rb_blue;
    end else if (e_ctl.drv || e_ctl.st == STATE_ERROR) begin
      out_next.red = 8'd255;
    end else if (e_ctl.under || e_ctl.st == STATE_HARD_LIMIT) begin
      blink        = e_ctl.blink80;
      out_next.red = blink ? 8'd255 : 8'd0;
    end else if (e_ctl.st == STATE_HOMING) begin
      blink        = e_ctl.blink250;
      out_next.red = blink ? 8'd255 : 8'd0;
    end else if (e_ctl.st == STATE_PATH) begin
      out_next.green = 8'd200;
      out_next.blue  = 8'd200;
    end else if (e_ctl.st == STATE_ACCEL || e_ctl.st == STATE_DECEL) begin
      out_next.red   = 8'd255;
      out_next.green = 8'd255;
    end else if (e_ctl.st == STATE_MOVING) begin
      out_next.green = 8'd255;
    end else if (e_ctl.st == STATE_IDLE) begin
      out_next.red   = 8'd31;
      out_next.blue  = 8'd31;
      out_next.green = e_ctl.link ? 8'd31 : 8'd0;
    end else begin
      // Disabled, and any state without a colour of its own, is dim orange.
      out_next.red   = 8'd31;
      out_next.green = 8'd11;
    end
    if (e_ctl.st < PATTERN_ROWS) begin
      out_next.led_on = PATTERN_ROM[e_ctl.st][e_ctl.phase];
    end
  end

endmodule
